// ===== src/srg_pkg.sv =====
// Package for the setpoint ramp generator: request codes, reset constants
// and the ramp state record passed between the top level and the update logic.
// No dependencies.
package srg_pkg;

    // Default number of ramp ticks in one minute (fixed-point scale)
    localparam int unsigned TICKS_PER_MINUTE_DEF = 480;

    // Reset setpoint and target, in centikelvin (295 K)
    localparam logic [15:0] RESET_CK = 16'd29500;

    // Request codes carried in req_type
    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_START    = 3'd1,
        REQ_SET      = 3'd2,
        REQ_MANUAL   = 3'd3,
        REQ_HEAT_ON  = 3'd4,
        REQ_HEAT_OFF = 3'd5,
        REQ_STOP     = 3'd6
    } req_t;

    // Ramp state. The setpoint is held as quotient and remainder of the
    // scaled accumulator; the remainder travels separately as its width
    // follows the tick scale. The target always has a zero remainder.
    typedef struct packed {
        logic [15:0] sp_q;      // setpoint, whole centikelvin
        logic [15:0] tgt_q;     // target, whole centikelvin
        logic [15:0] rate;      // ramp rate, centikelvin per minute
        logic [15:0] rate_q;    // rate / ticks per minute
        logic        active;
        logic        up;
        logic        heat;
    } srg_state_t;

endpackage

// ===== src/srg_update.sv =====
// Next-state logic of the setpoint ramp generator for one request word.
// Depends on srg_pkg (request codes, state record).
module srg_update #(
    parameter int unsigned TICKS_PER_MINUTE = srg_pkg::TICKS_PER_MINUTE_DEF
) (
    input  srg_pkg::srg_state_t                        st,
    input  logic [$clog2(TICKS_PER_MINUTE + 1) - 1:0]  sp_rem,
    input  logic [2:0]                                 req_type,
    input  logic [15:0]                                arg_a,
    input  logic [15:0]                                arg_b,
    output srg_pkg::srg_state_t                        st_next,
    output logic [$clog2(TICKS_PER_MINUTE + 1) - 1:0]  sp_rem_next,
    output logic                                       reached
);

    localparam int RW = $clog2(TICKS_PER_MINUTE + 1);
    // ceil(2^32 / T): exact quotient for any 16-bit dividend and 16-bit T
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(TICKS_PER_MINUTE) - 64'd1) / 64'(TICKS_PER_MINUTE));
    localparam logic [RW:0] TPM_W = (RW + 1)'(TICKS_PER_MINUTE);

    // Rate split into whole and fractional parts at ramp start
    logic [48:0] rq_prod;
    logic [15:0] start_rate_q;

    // Fractional part of the stored rate
    logic [31:0]   rq_times;
    logic [RW-1:0] rate_r;

    // Upward step
    logic [RW:0]   up_sum;
    logic          up_carry;
    logic [RW:0]   up_r;
    logic [17:0]   up_q;
    logic          up_hit;

    // Downward step
    logic          dn_borrow;
    logic [RW:0]   dn_r;
    logic [17:0]   dn_q;
    logic          dn_hit;

    assign rq_prod      = 49'(arg_b) * 49'(RECIP);
    assign start_rate_q = rq_prod[47:32];

    assign rq_times = 32'(st.rate_q) * 32'(TICKS_PER_MINUTE);
    assign rate_r   = RW'(32'(st.rate) - rq_times);

    // setpoint + rate, compared with the target
    assign up_sum   = {1'b0, sp_rem} + {1'b0, rate_r};
    assign up_carry = (up_sum >= TPM_W);
    assign up_r     = up_carry ? (up_sum - TPM_W) : up_sum;
    assign up_q     = 18'(st.sp_q) + 18'(st.rate_q) + 18'(up_carry);
    assign up_hit   = (up_q >= 18'(st.tgt_q));

    // setpoint - rate, compared with the target (quotient may go negative)
    assign dn_borrow = (sp_rem < rate_r);
    assign dn_r      = dn_borrow ? ({1'b0, sp_rem} + TPM_W - {1'b0, rate_r})
                                 : ({1'b0, sp_rem} - {1'b0, rate_r});
    assign dn_q      = 18'(st.sp_q) - 18'(st.rate_q) - 18'(dn_borrow);
    assign dn_hit    = ($signed(dn_q) < $signed(18'(st.tgt_q)))
                    || ((dn_q == 18'(st.tgt_q)) && (dn_r == '0));

    // Request decode
    always_comb
    begin
        st_next     = st;
        sp_rem_next = sp_rem;
        reached     = 1'b0;
        unique case (srg_pkg::req_t'(req_type))
            srg_pkg::REQ_TICK:
            begin
                if (st.active && st.heat)
                begin
                    if (st.up ? up_hit : dn_hit)
                    begin
                        st_next.sp_q   = st.tgt_q;
                        sp_rem_next    = '0;
                        st_next.active = 1'b0;
                        reached        = 1'b1;
                    end
                    else if (st.up)
                    begin
                        st_next.sp_q = up_q[15:0];
                        sp_rem_next  = up_r[RW-1:0];
                    end
                    else
                    begin
                        st_next.sp_q = dn_q[15:0];
                        sp_rem_next  = dn_r[RW-1:0];
                    end
                end
            end
            srg_pkg::REQ_START:
            begin
                st_next.tgt_q  = arg_a;
                st_next.rate   = arg_b;
                st_next.rate_q = start_rate_q;
                st_next.up     = (st.sp_q < arg_a);
                st_next.active = 1'b1;
            end
            srg_pkg::REQ_SET:
            begin
                st_next.sp_q   = arg_a;
                sp_rem_next    = '0;
                st_next.active = 1'b0;
            end
            srg_pkg::REQ_MANUAL:   st_next.active = 1'b0;
            srg_pkg::REQ_HEAT_ON:  st_next.heat   = 1'b1;
            srg_pkg::REQ_HEAT_OFF: st_next.heat   = 1'b0;
            srg_pkg::REQ_STOP:     st_next.active = 1'b0;
            default: ;
        endcase
    end

endmodule

// ===== src/setpoint_ramp_generator_top.sv =====
// Setpoint ramp generator top level: input register, ramp state, result register.
// Each input word is registered, and its result is registered once the result register is free.
// Throughput: one word per cycle; the input stalls only when both registers are
// full and the result is not taken.
// Reset (rst_n low, asynchronous): setpoint and target 295 K, rate zero, ramp and
// heater off, both registers empty. Depends on srg_pkg and srg_update.
module setpoint_ramp_generator_top #(
    parameter int unsigned TICKS_PER_MINUTE = srg_pkg::TICKS_PER_MINUTE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [15:0] arg_a,
    input  logic [15:0] arg_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] setpoint_ck,
    output logic        ramping,
    output logic        heating,
    output logic        ramp_reached
);

    localparam int RW = $clog2(TICKS_PER_MINUTE + 1);

    localparam srg_pkg::srg_state_t STATE_RESET = '{
        sp_q:   srg_pkg::RESET_CK,
        tgt_q:  srg_pkg::RESET_CK,
        rate:   16'd0,
        rate_q: 16'd0,
        active: 1'b0,
        up:     1'b0,
        heat:   1'b0
    };

    logic        in_valid_reg;
    logic [2:0]  req_reg;
    logic [15:0] arg_a_reg;
    logic [15:0] arg_b_reg;

    srg_pkg::srg_state_t state_reg;
    srg_pkg::srg_state_t state_next;
    logic [RW-1:0]       sp_rem_reg;
    logic [RW-1:0]       sp_rem_next;
    logic                reached_next;

    logic        out_valid_reg;
    logic [15:0] setpoint_ck_reg;
    logic        ramping_reg;
    logic        heating_reg;
    logic        ramp_reached_reg;

    logic advance;
    logic fire;

    // Handshake: result register frees when empty or taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg   <= req_type;
            arg_a_reg <= arg_a;
            arg_b_reg <= arg_b;
        end
    end

    // Update logic
    srg_update #(
        .TICKS_PER_MINUTE(TICKS_PER_MINUTE)
    ) u_update (
        .st          (state_reg),
        .sp_rem      (sp_rem_reg),
        .req_type    (req_reg),
        .arg_a       (arg_a_reg),
        .arg_b       (arg_b_reg),
        .st_next     (state_next),
        .sp_rem_next (sp_rem_next),
        .reached     (reached_next)
    );

    // Ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= STATE_RESET;
            sp_rem_reg <= '0;
        end
        else if (fire)
        begin
            state_reg  <= state_next;
            sp_rem_reg <= sp_rem_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            setpoint_ck_reg  <= state_next.sp_q;
            ramping_reg      <= state_next.active;
            heating_reg      <= state_next.heat;
            ramp_reached_reg <= reached_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign setpoint_ck  = setpoint_ck_reg;
    assign ramping      = ramping_reg;
    assign heating      = heating_reg;
    assign ramp_reached = ramp_reached_reg;

`ifndef SYNTH
    // Setpoint remainder stays below one whole centikelvin
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_rem_reg) < 32'(TICKS_PER_MINUTE))
        else $error("setpoint remainder out of range");

    // State moves only when a word passes into the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg) && $stable(sp_rem_reg))
        else $error("ramp state changed without a word");

    // Reaching the target always ends the ramp
    a_reached_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(ramp_reached_reg && ramping_reg))
        else $error("target reached while still ramping");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for setpoint_ramp_generator_top: directed and random
// command words against an in-bench prediction of the ramp state.
// Depends on srg_pkg and the RTL under src.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TPM        = srg_pkg::TICKS_PER_MINUTE_DEF;
    localparam logic [2:0]  REQ_UNUSED = 3'd7;   // code with no meaning
    localparam int unsigned DRAIN_MAX  = 10000;  // cycles allowed to empty the queue
    localparam int unsigned MAX_LINES  = 40;

    // One result word as the block reports it
    typedef struct packed {
        logic [15:0] sp_ck;
        logic        ramping;
        logic        heating;
        logic        reached;
    } ramp_status_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [15:0] arg_a;
    logic [15:0] arg_b;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] setpoint_ck;
    logic        ramping;
    logic        heating;
    logic        ramp_reached;

    // Predicted ramp state; accumulators in 1/TPM centikelvin
    logic [24:0] sp_acc;
    logic [24:0] tgt_acc;
    logic [15:0] step_rate;
    logic        ramp_on;
    logic        ramp_dir_up;
    logic        heat_on;

    ramp_status_t status_due[$];
    int unsigned  err_count;
    int unsigned  sender_idle_pct;
    int unsigned  recv_stall_pct;

    setpoint_ramp_generator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .arg_a        (arg_a),
        .arg_b        (arg_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .setpoint_ck  (setpoint_ck),
        .ramping      (ramping),
        .heating      (heating),
        .ramp_reached (ramp_reached)
    );

    // Clock
    always #5 clk = ~clk;

    // Scale whole centikelvin into accumulator units
    function automatic logic [24:0] to_acc(input logic [15:0] ck);
        return 25'(ck * TPM);
    endfunction

    // Apply one command word to the predicted state and return the status word
    function automatic ramp_status_t advance_ramp(input logic [2:0] code,
                                                  input logic [15:0] a,
                                                  input logic [15:0] b);
        ramp_status_t st;
        logic         hit;
        hit = 1'b0;
        case (code)
            srg_pkg::REQ_TICK:
            begin
                if (ramp_on && heat_on)
                begin
                    if (ramp_dir_up)
                    begin
                        if ({1'b0, sp_acc} + 26'(step_rate) >= {1'b0, tgt_acc})
                        begin
                            sp_acc  = tgt_acc;
                            ramp_on = 1'b0;
                            hit     = 1'b1;
                        end
                        else
                        begin
                            sp_acc = sp_acc + 25'(step_rate);
                        end
                    end
                    else
                    begin
                        if ({1'b0, sp_acc} <= {1'b0, tgt_acc} + 26'(step_rate))
                        begin
                            sp_acc  = tgt_acc;
                            ramp_on = 1'b0;
                            hit     = 1'b1;
                        end
                        else
                        begin
                            sp_acc = sp_acc - 25'(step_rate);
                        end
                    end
                end
            end
            srg_pkg::REQ_START:
            begin
                tgt_acc     = to_acc(a);
                step_rate   = b;
                ramp_dir_up = (sp_acc < tgt_acc);
                ramp_on     = 1'b1;
            end
            srg_pkg::REQ_SET:
            begin
                sp_acc  = to_acc(a);
                ramp_on = 1'b0;
            end
            srg_pkg::REQ_MANUAL:   ramp_on = 1'b0;
            srg_pkg::REQ_HEAT_ON:  heat_on = 1'b1;
            srg_pkg::REQ_HEAT_OFF: heat_on = 1'b0;
            srg_pkg::REQ_STOP:     ramp_on = 1'b0;
            default:               ;
        endcase
        st.sp_ck   = 16'(sp_acc / TPM);
        st.ramping = ramp_on;
        st.heating = heat_on;
        st.reached = hit;
        return st;
    endfunction

    // Print one mismatch line (capped) and count it
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_LINES)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // Offer one word, with random idle cycles ahead of it, and predict on acceptance
    task automatic send_word(input logic [2:0] code, input logic [15:0] a,
                             input logic [15:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= code;
        arg_a    <= a;
        arg_b    <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        status_due.push_back(advance_ramp(code, a, b));
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each status word with the oldest prediction
    always @(posedge clk)
    begin
        ramp_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word: sp=%0d ramp=%0b heat=%0b hit=%0b",
                                          setpoint_ck, ramping, heating, ramp_reached));
            end
            else
            begin
                want = status_due.pop_front();
                if (setpoint_ck !== want.sp_ck)
                    report_mismatch($sformatf("setpoint_ck %0d, want %0d",
                                              setpoint_ck, want.sp_ck));
                if (ramping !== want.ramping)
                    report_mismatch($sformatf("ramping %b, want %b", ramping, want.ramping));
                if (heating !== want.heating)
                    report_mismatch($sformatf("heating %b, want %b", heating, want.heating));
                if (ramp_reached !== want.reached)
                    report_mismatch($sformatf("ramp_reached %b, want %b",
                                              ramp_reached, want.reached));
            end
        end
    end

    // Extremes, every request and the corner cases, with no idling
    task automatic test_directed();
        send_word(srg_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF);   // tick with ramp and heater off
        send_word(REQ_UNUSED, 16'hA5A5, 16'h5A5A);          // unused code leaves state alone
        send_word(srg_pkg::REQ_HEAT_ON, 16'h0000, 16'hFFFF);
        send_word(srg_pkg::REQ_TICK, 16'h0000, 16'h0000);   // heater on, ramp stopped
        // zero rate downwards with setpoint equal to target: ends on first tick
        send_word(srg_pkg::REQ_START, srg_pkg::RESET_CK, 16'd0);
        send_word(srg_pkg::REQ_TICK, 16'h1234, 16'h4321);
        // zero rate upwards never ends
        send_word(srg_pkg::REQ_START, srg_pkg::RESET_CK + 16'd1, 16'd0);
        send_word(srg_pkg::REQ_TICK, 16'h0000, 16'h0000);
        send_word(srg_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF);
        send_word(srg_pkg::REQ_STOP, 16'hFFFF, 16'hFFFF);
        // full-scale ramp up from zero
        send_word(srg_pkg::REQ_SET, 16'd0, 16'hFFFF);
        send_word(srg_pkg::REQ_START, 16'hFFFF, 16'hFFFF);
        send_word(srg_pkg::REQ_TICK, 16'h0000, 16'h0000);
        send_word(srg_pkg::REQ_TICK, 16'h0000, 16'h0000);
        send_word(srg_pkg::REQ_MANUAL, 16'hFFFF, 16'hFFFF);
        // full-scale ramp down, paused by the heater
        send_word(srg_pkg::REQ_SET, 16'hFFFF, 16'h0000);
        send_word(srg_pkg::REQ_START, 16'd0, 16'hFFFF);
        send_word(srg_pkg::REQ_HEAT_OFF, 16'hFFFF, 16'hFFFF);
        send_word(srg_pkg::REQ_TICK, 16'h0000, 16'h0000);
        send_word(srg_pkg::REQ_HEAT_ON, 16'h0000, 16'h0000);
        send_word(srg_pkg::REQ_TICK, 16'h0000, 16'h0000);
        // large step just short of the target clamps and ends upwards
        send_word(srg_pkg::REQ_SET, 16'd100, 16'd0);
        send_word(srg_pkg::REQ_START, 16'd101, 16'hFFFF);
        send_word(srg_pkg::REQ_TICK, 16'h0000, 16'h0000);
        send_word(srg_pkg::REQ_TICK, 16'h0000, 16'h0000);   // ramp already over
    endtask

    // Start a ramp near the setpoint, then tick it, with some disturbance
    task automatic test_ramp_sequences(input int unsigned n_words);
        int unsigned sent;
        int unsigned cur_ck;
        int unsigned delta;
        int unsigned tgt_ck;
        int unsigned n_ticks;
        logic [15:0] rate;
        sent = 0;
        while (sent < n_words)
        begin
            if (!heat_on || $urandom_range(99) < 10)
            begin
                send_word(srg_pkg::REQ_HEAT_ON, 16'($urandom), 16'($urandom));
                sent++;
            end
            cur_ck = sp_acc / TPM;
            delta  = $urandom_range(40);
            if ($urandom_range(1) == 1)
                tgt_ck = (cur_ck + delta > 65535) ? 65535 : cur_ck + delta;
            else
                tgt_ck = (cur_ck < delta) ? 0 : cur_ck - delta;
            case ($urandom_range(9))
                0:       rate = 16'($urandom_range(15));
                1:       rate = 16'hFFFF;
                default: rate = 16'($urandom_range(65535, 1500));
            endcase
            send_word(srg_pkg::REQ_START, 16'(tgt_ck), rate);
            sent++;
            n_ticks = $urandom_range(16, 1);
            while (n_ticks != 0 && ramp_on)
            begin
                case ($urandom_range(39))
                    0: send_word(srg_pkg::REQ_HEAT_OFF, 16'($urandom), 16'($urandom));
                    1: send_word(srg_pkg::REQ_STOP, 16'($urandom), 16'($urandom));
                    2: send_word(srg_pkg::REQ_MANUAL, 16'($urandom), 16'($urandom));
                    3: send_word(srg_pkg::REQ_SET, 16'($urandom), 16'($urandom));
                    4: send_word(REQ_UNUSED, 16'($urandom), 16'($urandom));
                    default: send_word(srg_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
                endcase
                sent++;
                n_ticks--;
            end
        end
    endtask

    // Fully random words over every code and every argument bit
    task automatic test_random_words(input int unsigned n_words);
        repeat (n_words)
            send_word(3'($urandom_range(7)), 16'($urandom), 16'($urandom));
    endtask

    // Main sequence
    initial
    begin
        int unsigned guard;
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        req_type        = srg_pkg::REQ_TICK;
        arg_a           = 16'd0;
        arg_b           = 16'd0;
        out_ready       = 1'b0;
        err_count       = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        sp_acc          = to_acc(srg_pkg::RESET_CK);
        tgt_acc         = to_acc(srg_pkg::RESET_CK);
        step_rate       = 16'd0;
        ramp_on         = 1'b0;
        ramp_dir_up     = 1'b0;
        heat_on         = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();

        // idling phases: none, sender, receiver, both
        sender_idle_pct = 0;  recv_stall_pct = 0;
        test_ramp_sequences(100);
        test_random_words(25);
        sender_idle_pct = 61; recv_stall_pct = 0;
        test_ramp_sequences(100);
        test_random_words(25);
        sender_idle_pct = 0;  recv_stall_pct = 61;
        test_ramp_sequences(100);
        test_random_words(25);
        sender_idle_pct = 16; recv_stall_pct = 16;
        test_ramp_sequences(100);
        test_random_words(25);

        in_valid <= 1'b0;

        // drain, then wait a few more cycles to catch strays
        guard = 0;
        while (status_due.size() != 0 && guard < DRAIN_MAX)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (status_due.size() != 0)
            report_mismatch($sformatf("%0d status words never arrived", status_due.size()));

        if (err_count == 0)
            $display("PASS setpoint_ramp_generator_top");
        else
            $display("FAIL setpoint_ramp_generator_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAIL setpoint_ramp_generator_top");
        $finish;
    end

endmodule

// ===== files.f =====
src/srg_pkg.sv
src/srg_update.sv
src/setpoint_ramp_generator_top.sv
tb/tb.sv
